// ----- design/rbcd_pkg.sv -----
`default_nettype none

package rbcd_pkg;

  // Restoring divider for the reciprocal terms, one quotient bit per stage
  localparam int unsigned DIV_W     = 20;
  localparam int unsigned DEN_W     = 11;
  localparam int unsigned DIV_LAT   = DIV_W + 1;
  localparam int unsigned LANE_LAT  = DIV_LAT + 4;
  localparam int unsigned MERGE_LAT = 2;
  localparam int unsigned PIPE_LAT  = LANE_LAT + MERGE_LAT;

  localparam logic [DIV_W-1:0] NUM_SAT = 20'hFF000;  // 255 << 12
  localparam logic [DIV_W-1:0] NUM_HUE = 20'hB4000;  // 180 << 12
  localparam int unsigned      HSV_SHIFT  = 12;
  localparam int unsigned      ROUND_HALF = 2048;
  localparam logic [7:0]       HUE_WRAP   = 8'd180;

  localparam int unsigned NUM_BOXES = 12;
  localparam int unsigned POW_W     = 30;
  localparam int unsigned OHMS_W    = 37;

  typedef enum logic [3:0] {
    CLS_RED     = 4'd0,
    CLS_ORANGE  = 4'd1,
    CLS_YELLOW  = 4'd2,
    CLS_GREEN   = 4'd3,
    CLS_BLUE    = 4'd4,
    CLS_VIOLET  = 4'd5,
    CLS_WHITE   = 4'd6,
    CLS_BLACK   = 4'd7,
    CLS_GRAY    = 4'd8,
    CLS_BROWN   = 4'd9,
    CLS_GOLD    = 4'd10,
    CLS_SILVER  = 4'd11,
    CLS_UNKNOWN = 4'd12
  } class_e;

  typedef struct packed {
    logic [7:0] h_lo;
    logic [7:0] s_lo;
    logic [7:0] v_lo;
    logic [7:0] h_hi;
    logic [7:0] s_hi;
    logic [7:0] v_hi;
  } box_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  localparam box_t BOX_TABLE [NUM_BOXES] = '{
    '{8'd0,   8'd70,  8'd50,  8'd10,  8'd255, 8'd255},
    '{8'd10,  8'd100, 8'd100, 8'd25,  8'd255, 8'd255},
    '{8'd25,  8'd100, 8'd100, 8'd35,  8'd255, 8'd255},
    '{8'd35,  8'd50,  8'd50,  8'd85,  8'd255, 8'd255},
    '{8'd85,  8'd50,  8'd50,  8'd130, 8'd255, 8'd255},
    '{8'd130, 8'd50,  8'd50,  8'd160, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd200, 8'd180, 8'd20,  8'd255},
    '{8'd0,   8'd0,   8'd0,   8'd180, 8'd255, 8'd30},
    '{8'd0,   8'd0,   8'd50,  8'd180, 8'd50,  8'd200},
    '{8'd0,   8'd50,  8'd50,  8'd10,  8'd100, 8'd200},
    '{8'd20,  8'd50,  8'd50,  8'd30,  8'd100, 8'd200},
    '{8'd0,   8'd0,   8'd150, 8'd20,  8'd100, 8'd200}
  };

  // First matching box wins: scan from the bottom so earlier rows overwrite
  function automatic logic [3:0] classify(input logic [7:0] h, input logic [7:0] s,
                                          input logic [7:0] v);
    logic [3:0] cls;
    cls = CLS_UNKNOWN;
    for (int i = NUM_BOXES - 1; i >= 0; i--) begin
      if (h >= BOX_TABLE[i].h_lo && h <= BOX_TABLE[i].h_hi &&
          s >= BOX_TABLE[i].s_lo && s <= BOX_TABLE[i].s_hi &&
          v >= BOX_TABLE[i].v_lo && v <= BOX_TABLE[i].v_hi) begin
        cls = 4'(i);
      end
    end
    return cls;
  endfunction

  function automatic digit_t class_digit(input logic [3:0] cls);
    digit_t d;
    d.ok = 1'b1;
    case (class_e'(cls))
      CLS_BLACK:  d.val = 4'd0;
      CLS_BROWN:  d.val = 4'd1;
      CLS_RED:    d.val = 4'd2;
      CLS_ORANGE: d.val = 4'd3;
      CLS_YELLOW: d.val = 4'd4;
      CLS_GREEN:  d.val = 4'd5;
      CLS_BLUE:   d.val = 4'd6;
      CLS_VIOLET: d.val = 4'd7;
      CLS_GRAY:   d.val = 4'd8;
      CLS_WHITE:  d.val = 4'd9;
      default: begin
        d.ok  = 1'b0;
        d.val = 4'd0;
      end
    endcase
    return d;
  endfunction

  function automatic logic [POW_W-1:0] pow10(input logic [3:0] e);
    logic [POW_W-1:0] p;
    case (e)
      4'd0:    p = POW_W'(1);
      4'd1:    p = POW_W'(10);
      4'd2:    p = POW_W'(100);
      4'd3:    p = POW_W'(1000);
      4'd4:    p = POW_W'(10000);
      4'd5:    p = POW_W'(100000);
      4'd6:    p = POW_W'(1000000);
      4'd7:    p = POW_W'(10000000);
      4'd8:    p = POW_W'(100000000);
      4'd9:    p = POW_W'(1000000000);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- design/resistor_band_color_decoder.sv -----
// Resistor band color decoder.
// Input: one transaction carries three BGR pixels, one per band (first digit,
// second digit, multiplier). A transaction is taken at a rising edge with
// start high and busy low.
// Output: done_o is high for exactly one cycle with the three band classes,
// value_valid_o and resistance_ohms_o (zero when not valid). There is no
// back-pressure: the result must be taken in that cycle.
// Pipeline: max/min and hue numerator, the bit-per-stage reciprocal
// dividers in each band lane, the products, HSV scaling, box classification,
// then digit decode and the ohms multiply.
// Throughput: one transaction per cycle while busy is low; the three bands
// run in parallel lanes and the pipeline can hold a transaction in every stage.
// Reset: asynchronous, active low, clears the in-flight markers so no result
// appears after reset; busy is high during reset and until the first rising
// edge after it, then stays low.
`default_nettype none

module resistor_band_color_decoder import rbcd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [7:0]        band1_blue_i,
  input  wire logic [7:0]        band1_green_i,
  input  wire logic [7:0]        band1_red_i,
  input  wire logic [7:0]        band2_blue_i,
  input  wire logic [7:0]        band2_green_i,
  input  wire logic [7:0]        band2_red_i,
  input  wire logic [7:0]        band3_blue_i,
  input  wire logic [7:0]        band3_green_i,
  input  wire logic [7:0]        band3_red_i,
  output logic                   done_o,
  output logic      [3:0]        band1_class_o,
  output logic      [3:0]        band2_class_o,
  output logic      [3:0]        band3_class_o,
  output logic                   value_valid_o,
  output logic      [OHMS_W-1:0] resistance_ohms_o
);

  logic                busy_q;
  logic [PIPE_LAT-1:0] vld_q;
  logic                accept;

  assign accept = start && !busy_q;
  assign busy   = busy_q;
  assign done_o = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[PIPE_LAT-2:0], accept};
    end
  end

  logic [3:0] cls1, cls2, cls3;

  rbcd_lane u_lane1 (
    .clk_i   (clk_i),
    .blue_i  (band1_blue_i),
    .green_i (band1_green_i),
    .red_i   (band1_red_i),
    .class_o (cls1)
  );

  rbcd_lane u_lane2 (
    .clk_i   (clk_i),
    .blue_i  (band2_blue_i),
    .green_i (band2_green_i),
    .red_i   (band2_red_i),
    .class_o (cls2)
  );

  rbcd_lane u_lane3 (
    .clk_i   (clk_i),
    .blue_i  (band3_blue_i),
    .green_i (band3_green_i),
    .red_i   (band3_red_i),
    .class_o (cls3)
  );

  rbcd_merge u_merge (
    .clk_i             (clk_i),
    .class1_i          (cls1),
    .class2_i          (cls2),
    .class3_i          (cls3),
    .band1_class_o     (band1_class_o),
    .band2_class_o     (band2_class_o),
    .band3_class_o     (band3_class_o),
    .value_valid_o     (value_valid_o),
    .resistance_ohms_o (resistance_ohms_o)
  );

endmodule

`default_nettype wire

// ----- design/rbcd_div.sv -----
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, then a
// round-to-nearest-even stage. num_i is a static constant at each instance.
module rbcd_div import rbcd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [DIV_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [DIV_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [DIV_W];
  logic [DEN_W-1:0] den_q [DIV_W];
  logic [DIV_W-1:0] quo_q [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [DIV_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, num_i[DIV_W-1-k]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[DIV_W-2:0], ge};
    end
  end

  logic [DEN_W:0] rem_x2;
  logic [DEN_W:0] den_x;
  logic           rnd_up;

  assign rem_x2 = {rem_q[DIV_W-1], 1'b0};
  assign den_x  = {1'b0, den_q[DIV_W-1]};
  assign rnd_up = (rem_x2 > den_x) || ((rem_x2 == den_x) && quo_q[DIV_W-1][0]);

  always_ff @(posedge clk_i) begin
    quo_o <= quo_q[DIV_W-1] + DIV_W'(rnd_up);
  end

endmodule

`default_nettype wire

// ----- design/rbcd_lane.sv -----
`default_nettype none

// One band: BGR -> HSV -> color class
module rbcd_lane import rbcd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic [7:0] blue_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] red_i,
  output logic      [3:0] class_o
);

  // stage 0: max, min, hue numerator
  logic [7:0]         vmax, vmin, diff;
  logic signed [11:0] bs, gs, rs, ds, hnum;

  always_comb begin
    vmax = blue_i;
    if (green_i > vmax) vmax = green_i;
    if (red_i > vmax) vmax = red_i;
    vmin = blue_i;
    if (green_i < vmin) vmin = green_i;
    if (red_i < vmin) vmin = red_i;
    diff = vmax - vmin;
    bs   = $signed({4'b0, blue_i});
    gs   = $signed({4'b0, green_i});
    rs   = $signed({4'b0, red_i});
    ds   = $signed({4'b0, diff});
    if (vmax == red_i) begin
      hnum = gs - bs;
    end else if (vmax == green_i) begin
      hnum = bs - rs + (ds <<< 1);
    end else begin
      hnum = rs - gs + (ds <<< 2);
    end
  end

  logic [7:0]         v0_q, diff0_q;
  logic signed [11:0] hnum0_q;

  always_ff @(posedge clk_i) begin
    v0_q    <= vmax;
    diff0_q <= diff;
    hnum0_q <= hnum;
  end

  // reciprocals: round(255*4096/v) and round(180*4096/(6*diff))
  logic [DIV_W-1:0] q_sat, q_hue;
  logic [DEN_W-1:0] den_hue;

  assign den_hue = DEN_W'(diff0_q) * DEN_W'(6);

  rbcd_div u_div_sat (
    .clk_i (clk_i),
    .num_i (NUM_SAT),
    .den_i (DEN_W'(v0_q)),
    .quo_o (q_sat)
  );

  rbcd_div u_div_hue (
    .clk_i (clk_i),
    .num_i (NUM_HUE),
    .den_i (den_hue),
    .quo_o (q_hue)
  );

  logic [7:0]         v_dl_q    [DIV_LAT];
  logic [7:0]         diff_dl_q [DIV_LAT];
  logic signed [11:0] hnum_dl_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    v_dl_q[0]    <= v0_q;
    diff_dl_q[0] <= diff0_q;
    hnum_dl_q[0] <= hnum0_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      v_dl_q[i]    <= v_dl_q[i-1];
      diff_dl_q[i] <= diff_dl_q[i-1];
      hnum_dl_q[i] <= hnum_dl_q[i-1];
    end
  end

  // products
  logic [27:0]        ps_full;
  logic signed [32:0] ph_full;
  logic [27:0]        ps_q;
  logic signed [29:0] ph_q;
  logic [7:0]         v22_q;
  logic               vz_q, dz_q;

  assign ps_full = diff_dl_q[DIV_LAT-1] * q_sat;
  assign ph_full = hnum_dl_q[DIV_LAT-1] * $signed({1'b0, q_hue});

  always_ff @(posedge clk_i) begin
    ps_q  <= ps_full;
    ph_q  <= $signed(ph_full[29:0]);
    v22_q <= v_dl_q[DIV_LAT-1];
    vz_q  <= (v_dl_q[DIV_LAT-1] == 8'd0);
    dz_q  <= (diff_dl_q[DIV_LAT-1] == 8'd0);
  end

  // round and scale back
  logic [28:0]        ps_r;
  logic signed [29:0] ph_r, ph_sh;
  logic signed [8:0]  h9;
  logic [7:0]         s_d, h_d;

  always_comb begin
    ps_r  = {1'b0, ps_q} + 29'(ROUND_HALF);
    ph_r  = ph_q + $signed(30'(ROUND_HALF));
    ph_sh = ph_r >>> HSV_SHIFT;
    s_d   = vz_q ? 8'd0 : ps_r[HSV_SHIFT+7:HSV_SHIFT];
    h9    = dz_q ? 9'sd0 : $signed(ph_sh[8:0]);
    if (h9 < 0) begin
      h9 = h9 + $signed({1'b0, HUE_WRAP});
    end
    h_d = h9[7:0];
  end

  logic [7:0] h_q, s_q, v_q;

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    s_q <= s_d;
    v_q <= v22_q;
  end

  always_ff @(posedge clk_i) begin
    class_o <= classify(h_q, s_q, v_q);
  end

endmodule

`default_nettype wire

// ----- design/rbcd_merge.sv -----
`default_nettype none

// Combine the three band classes into the ohms value
module rbcd_merge import rbcd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic [3:0]        class1_i,
  input  wire logic [3:0]        class2_i,
  input  wire logic [3:0]        class3_i,
  output logic      [3:0]        band1_class_o,
  output logic      [3:0]        band2_class_o,
  output logic      [3:0]        band3_class_o,
  output logic                   value_valid_o,
  output logic      [OHMS_W-1:0] resistance_ohms_o
);

  digit_t d1, d2, d3;

  assign d1 = class_digit(class1_i);
  assign d2 = class_digit(class2_i);
  assign d3 = class_digit(class3_i);

  logic [3:0]       c1_q, c2_q, c3_q;
  logic             ok_q;
  logic [6:0]       two_q;
  logic [POW_W-1:0] pw_q;

  always_ff @(posedge clk_i) begin
    c1_q  <= class1_i;
    c2_q  <= class2_i;
    c3_q  <= class3_i;
    ok_q  <= d1.ok && d2.ok && d3.ok;
    two_q <= 7'(d1.val) * 7'd10 + 7'(d2.val);
    pw_q  <= pow10(d3.val);
  end

  logic [OHMS_W-1:0] prod;

  assign prod = OHMS_W'(two_q) * OHMS_W'(pw_q);

  always_ff @(posedge clk_i) begin
    band1_class_o     <= c1_q;
    band2_class_o     <= c2_q;
    band3_class_o     <= c3_q;
    value_valid_o     <= ok_q;
    resistance_ohms_o <= ok_q ? prod : '0;
  end

endmodule

`default_nettype wire

// ----- design/rbcd_chk.sv -----
`default_nettype none

module rbcd_chk import rbcd_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire logic [3:0]        band1_class_o,
  input wire logic [3:0]        band2_class_o,
  input wire logic [3:0]        band3_class_o,
  input wire logic              value_valid_o,
  input wire logic [OHMS_W-1:0] resistance_ohms_o
);

  localparam logic [OHMS_W-1:0] OHMS_MAX = 37'd99000000000;

  // every accepted transaction yields a result a fixed time later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(PIPE_LAT) done_o)
    else $error("result missing after accepted transaction");

  // no result without a matching transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result without transaction");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !value_valid_o |-> resistance_ohms_o == '0)
    else $error("nonzero ohms on invalid result");

  a_valid_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && value_valid_o |-> band1_class_o < CLS_GOLD && band2_class_o < CLS_GOLD &&
                                band3_class_o < CLS_GOLD)
    else $error("valid value with non-digit band");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> resistance_ohms_o <= OHMS_MAX && band1_class_o <= CLS_UNKNOWN &&
               band2_class_o <= CLS_UNKNOWN && band3_class_o <= CLS_UNKNOWN)
    else $error("result field out of range");

endmodule

bind resistor_band_color_decoder rbcd_chk u_chk (.*);

`default_nettype wire

// ----- test/tb_resistor_band_color_decoder.sv -----
`default_nettype none

module tb_resistor_band_color_decoder;
  import rbcd_pkg::*;

  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     SETTLE_CYCLES = PIPE_LAT + 8;
  localparam int     MAX_PRINTED   = 40;
  localparam longint SHIFT_HALF    = 2048;
  localparam longint SHIFT_MASK    = 4095;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    pixel_t band1;
    pixel_t band2;
    pixel_t band3;
  } triple_t;

  typedef struct packed {
    logic [3:0]        cls1;
    logic [3:0]        cls2;
    logic [3:0]        cls3;
    logic              valid;
    logic [OHMS_W-1:0] ohms;
  } decode_t;

  typedef struct packed {
    logic [8:0] h_lo;
    logic [8:0] s_lo;
    logic [8:0] v_lo;
    logic [8:0] h_hi;
    logic [8:0] s_hi;
    logic [8:0] v_hi;
  } hsv_box_t;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b1;
  logic              start  = 1'b0;
  logic              busy;
  logic [7:0]        band1_blue_i  = '0;
  logic [7:0]        band1_green_i = '0;
  logic [7:0]        band1_red_i   = '0;
  logic [7:0]        band2_blue_i  = '0;
  logic [7:0]        band2_green_i = '0;
  logic [7:0]        band2_red_i   = '0;
  logic [7:0]        band3_blue_i  = '0;
  logic [7:0]        band3_green_i = '0;
  logic [7:0]        band3_red_i   = '0;
  logic              done_o;
  logic [3:0]        band1_class_o;
  logic [3:0]        band2_class_o;
  logic [3:0]        band3_class_o;
  logic              value_valid_o;
  logic [OHMS_W-1:0] resistance_ohms_o;

  decode_t expected_decodes[$];
  decode_t oldest_decode;
  int      mismatch_count = 0;
  int      cycle_count    = 0;

  resistor_band_color_decoder i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .band1_blue_i      (band1_blue_i),
    .band1_green_i     (band1_green_i),
    .band1_red_i       (band1_red_i),
    .band2_blue_i      (band2_blue_i),
    .band2_green_i     (band2_green_i),
    .band2_red_i       (band2_red_i),
    .band3_blue_i      (band3_blue_i),
    .band3_green_i     (band3_green_i),
    .band3_red_i       (band3_red_i),
    .done_o            (done_o),
    .band1_class_o     (band1_class_o),
    .band2_class_o     (band2_class_o),
    .band3_class_o     (band3_class_o),
    .value_valid_o     (value_valid_o),
    .resistance_ohms_o (resistance_ohms_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Color prediction
  // ---------------------------------------------------------------------------

  function automatic hsv_box_t color_box(input int idx);
    hsv_box_t bx;
    case (idx)
      0:       bx = '{0,   70,  50,  10,  255, 255};
      1:       bx = '{10,  100, 100, 25,  255, 255};
      2:       bx = '{25,  100, 100, 35,  255, 255};
      3:       bx = '{35,  50,  50,  85,  255, 255};
      4:       bx = '{85,  50,  50,  130, 255, 255};
      5:       bx = '{130, 50,  50,  160, 255, 255};
      6:       bx = '{0,   0,   200, 180, 20,  255};
      7:       bx = '{0,   0,   0,   180, 255, 30};
      8:       bx = '{0,   0,   50,  180, 50,  200};
      9:       bx = '{0,   50,  50,  10,  100, 200};
      10:      bx = '{20,  50,  50,  30,  100, 200};
      11:      bx = '{0,   0,   150, 20,  100, 200};
      // region outside every box, only used to build unknown pixels
      default: bx = '{162, 110, 80,  178, 255, 255};
    endcase
    return bx;
  endfunction

  function automatic longint round_div_even(input longint num, input longint den);
    longint q;
    longint r;
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q++;
    return q;
  endfunction

  function automatic longint floor_div_4096(input longint x);
    if (x >= 0) return x >>> 12;
    return -((-x + SHIFT_MASK) >>> 12);
  endfunction

  function automatic class_e hsv_class(input pixel_t px);
    int       b, g, r, v, vmin, diff;
    longint   sat, hue, hnum;
    hsv_box_t bx;
    b    = px.blue;
    g    = px.green;
    r    = px.red;
    v    = b;
    vmin = b;
    if (g > v) v = g;
    if (r > v) v = r;
    if (g < vmin) vmin = g;
    if (r < vmin) vmin = r;
    diff = v - vmin;
    sat  = 0;
    hue  = 0;
    if (v != 0) sat = (diff * round_div_even(longint'(255) <<< 12, v) + SHIFT_HALF) >>> 12;
    if (v == r) hnum = g - b;
    else if (v == g) hnum = b - r + 2 * diff;
    else hnum = r - g + 4 * diff;
    if (diff != 0)
      hue = floor_div_4096(hnum * round_div_even(longint'(180) <<< 12, 6 * diff)
                           + SHIFT_HALF);
    if (hue < 0) hue += 180;
    for (int i = 0; i < 12; i++) begin
      bx = color_box(i);
      if (hue >= int'(bx.h_lo) && hue <= int'(bx.h_hi) &&
          sat >= int'(bx.s_lo) && sat <= int'(bx.s_hi) &&
          v >= int'(bx.v_lo) && v <= int'(bx.v_hi)) begin
        return class_e'(i);
      end
    end
    return CLS_UNKNOWN;
  endfunction

  function automatic int band_digit(input class_e cls);
    case (cls)
      CLS_BLACK:  return 0;
      CLS_BROWN:  return 1;
      CLS_RED:    return 2;
      CLS_ORANGE: return 3;
      CLS_YELLOW: return 4;
      CLS_GREEN:  return 5;
      CLS_BLUE:   return 6;
      CLS_VIOLET: return 7;
      CLS_GRAY:   return 8;
      CLS_WHITE:  return 9;
      default:    return -1;
    endcase
  endfunction

  function automatic decode_t predict_decode(input triple_t t);
    decode_t         d;
    class_e          c1, c2, c3;
    int              d1, d2, d3;
    longint unsigned ohms;
    c1     = hsv_class(t.band1);
    c2     = hsv_class(t.band2);
    c3     = hsv_class(t.band3);
    d1     = band_digit(c1);
    d2     = band_digit(c2);
    d3     = band_digit(c3);
    d.cls1 = c1;
    d.cls2 = c2;
    d.cls3 = c3;
    d.valid = 1'b0;
    d.ohms  = '0;
    if (d1 >= 0 && d2 >= 0 && d3 >= 0) begin
      ohms = d1 * 10 + d2;
      for (int k = 0; k < d3; k++) ohms = ohms * 10;
      d.valid = 1'b1;
      d.ohms  = OHMS_W'(ohms);
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Picks HSV inside the class box, converts back to BGR and keeps the pixel
  // only if it really lands in that class (boxes overlap, rounding moves hue).
  function automatic pixel_t pixel_for(input int cls);
    hsv_box_t bx;
    pixel_t   px;
    int       h, s, v, mn, span, sector, f, rise, fall, h_top;
    bx    = color_box(cls);
    px    = '0;
    h_top = (int'(bx.h_hi) > 179) ? 179 : int'(bx.h_hi);
    for (int k = 0; k < 64; k++) begin
      h      = $urandom_range(h_top, int'(bx.h_lo));
      s      = $urandom_range(int'(bx.s_hi), int'(bx.s_lo));
      v      = $urandom_range(int'(bx.v_hi), int'(bx.v_lo));
      mn     = v - (s * v) / 255;
      span   = v - mn;
      sector = (h * 6) / 180;
      f      = (h * 6) % 180;
      rise   = mn + span * f / 180;
      fall   = v - span * f / 180;
      case (sector)
        0:       begin px.red = 8'(v);    px.green = 8'(rise); px.blue = 8'(mn);   end
        1:       begin px.red = 8'(fall); px.green = 8'(v);    px.blue = 8'(mn);   end
        2:       begin px.red = 8'(mn);   px.green = 8'(v);    px.blue = 8'(rise); end
        3:       begin px.red = 8'(mn);   px.green = 8'(fall); px.blue = 8'(v);    end
        4:       begin px.red = 8'(rise); px.green = 8'(mn);   px.blue = 8'(v);    end
        default: begin px.red = 8'(v);    px.green = 8'(mn);   px.blue = 8'(fall); end
      endcase
      if (hsv_class(px) == class_e'(cls)) return px;
    end
    return px;
  endfunction

  function automatic pixel_t noise_pixel();
    pixel_t px;
    px.blue  = 8'($urandom);
    px.green = 8'($urandom);
    px.red   = 8'($urandom);
    return px;
  endfunction

  function automatic pixel_t rgb(input int r, input int g, input int b);
    pixel_t px;
    px.red   = 8'(r);
    px.green = 8'(g);
    px.blue  = 8'(b);
    return px;
  endfunction

  // Mostly three digit colors; otherwise one band is spoiled.
  function automatic triple_t resistor_triple();
    triple_t t;
    int      bad_band;
    pixel_t  bad_px;
    t.band1 = pixel_for($urandom_range(9, 0));
    t.band2 = pixel_for($urandom_range(9, 0));
    t.band3 = pixel_for($urandom_range(9, 0));
    if ($urandom_range(0, 4) == 0) begin
      bad_band = $urandom_range(2, 0);
      bad_px   = ($urandom_range(0, 3) == 0) ? noise_pixel() : pixel_for($urandom_range(12, 10));
      case (bad_band)
        0:       t.band1 = bad_px;
        1:       t.band2 = bad_px;
        default: t.band3 = bad_px;
      endcase
    end
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic send_triple(input triple_t t);
    start         <= 1'b1;
    band1_blue_i  <= t.band1.blue;
    band1_green_i <= t.band1.green;
    band1_red_i   <= t.band1.red;
    band2_blue_i  <= t.band2.blue;
    band2_green_i <= t.band2.green;
    band2_red_i   <= t.band2.red;
    band3_blue_i  <= t.band3.blue;
    band3_green_i <= t.band3.green;
    band3_red_i   <= t.band3.red;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_decodes.push_back(predict_decode(t));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_idle(input bit enabled);
    if (enabled && $urandom_range(0, 3) == 0) pause_sender($urandom_range(17, 1));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_decodes.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_extreme_pixels();
    triple_t t;
    // all zero (black, saturation zero) and all ones (white, hue zero)
    t = '{rgb(0, 0, 0), rgb(0, 0, 0), rgb(0, 0, 0)};
    send_triple(t);
    t = '{rgb(255, 255, 255), rgb(255, 255, 255), rgb(255, 255, 255)};
    send_triple(t);
    // grays with max equal to min
    t = '{rgb(128, 128, 128), rgb(40, 40, 40), rgb(180, 180, 180)};
    send_triple(t);
    // pure primaries
    t = '{rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255)};
    send_triple(t);
    // red max with blue above green: hue wraps from negative
    t = '{rgb(255, 0, 10), rgb(200, 30, 60), rgb(255, 0, 1)};
    send_triple(t);
    // magenta-ish, outside every box
    t = '{rgb(255, 0, 100), rgb(200, 20, 120), rgb(255, 0, 60)};
    send_triple(t);
    // largest value: white, white, white
    t = '{pixel_for(CLS_WHITE), pixel_for(CLS_WHITE), pixel_for(CLS_WHITE)};
    send_triple(t);
    // smallest nonzero digit pattern: black, brown, black
    t = '{pixel_for(CLS_BLACK), pixel_for(CLS_BROWN), pixel_for(CLS_BLACK)};
    send_triple(t);
    pause_sender($urandom_range(17, 1));
  endtask

  task automatic test_each_color();
    triple_t t;
    for (int c = 0; c < 13; c++) begin
      t.band1 = pixel_for(c);
      t.band2 = pixel_for((c + 1) % 13);
      t.band3 = pixel_for((c + 2) % 13);
      send_triple(t);
      maybe_idle(1'b1);
    end
  endtask

  task automatic test_random_noise(input int count);
    triple_t t;
    bit      idle_on;
    idle_on = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      t = '{noise_pixel(), noise_pixel(), noise_pixel()};
      send_triple(t);
      maybe_idle(idle_on);
    end
  endtask

  task automatic test_random_resistors(input int count);
    bit idle_on;
    idle_on = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      send_triple(resistor_triple());
      maybe_idle(idle_on);
    end
  endtask

  // sender holds off until the pipeline is empty, then restarts
  task automatic test_drain_pause();
    for (int round = 0; round < 2; round++) begin
      for (int n = 0; n < 10; n++) send_triple(resistor_triple());
      drain_results();
    end
  endtask

  task automatic test_back_to_back(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) send_triple('{noise_pixel(), noise_pixel(), noise_pixel()});
      else send_triple(resistor_triple());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_decodes.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        oldest_decode = expected_decodes.pop_front();
        if (band1_class_o !== oldest_decode.cls1)
          report_mismatch($sformatf("band1_class got %0d exp %0d",
                                    band1_class_o, oldest_decode.cls1));
        if (band2_class_o !== oldest_decode.cls2)
          report_mismatch($sformatf("band2_class got %0d exp %0d",
                                    band2_class_o, oldest_decode.cls2));
        if (band3_class_o !== oldest_decode.cls3)
          report_mismatch($sformatf("band3_class got %0d exp %0d",
                                    band3_class_o, oldest_decode.cls3));
        if (value_valid_o !== oldest_decode.valid)
          report_mismatch($sformatf("value_valid got %0b exp %0b",
                                    value_valid_o, oldest_decode.valid));
        if (resistance_ohms_o !== oldest_decode.ohms)
          report_mismatch($sformatf("resistance_ohms got %0d exp %0d",
                                    resistance_ohms_o, oldest_decode.ohms));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    // falling edge at time zero so the asynchronous reset really fires
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_pixels();
    test_each_color();
    test_random_noise(200);
    test_random_resistors(400);
    test_drain_pause();
    test_back_to_back(160);

    start <= 1'b0;
    @(posedge clk_i);
    while (expected_decodes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
